/* src/bsp_pkg.sv */
// Package for the box screen projection block: register codes, side-band
// structs and the 16-bit saturation helper. Depends on nothing.
package bsp_pkg;

    localparam int unsigned NUM_CORNERS   = 8;
    localparam int unsigned MIN_CORNERS   = 4;
    localparam int          DEPTH_MIN_Q22 = 41944;
    localparam int unsigned OFFSET_CAP    = 1 << 20;
    localparam int unsigned COLOUR_SCALE  = 510;
    localparam int unsigned COLOUR_FULL   = 255;

    typedef enum logic [2:0] {
        REG_CAMERA_X,
        REG_CAMERA_Y,
        REG_CAMERA_Z,
        REG_RIGHT_AXIS,
        REG_UP_AXIS,
        REG_FORWARD_AXIS,
        REG_PROJECTION_SCALES,
        REG_MODE_FLAGS
    } cfg_reg_t;

    typedef struct packed {
        logic        first;
        logic        last;
        logic [15:0] health_now;
        logic [15:0] health_full;
    } corner_tag_t;

    typedef struct packed {
        logic [47:0] right_axis;
        logic [47:0] up_axis;
        logic [47:0] forward_axis;
        logic [31:0] scale_x;
        logic [31:0] scale_y;
        logic [15:0] half_w;
        logic [15:0] half_h;
    } proj_cfg_t;

    typedef struct packed {
        logic               visible;
        logic               draw_box;
        logic               bar_on;
        logic signed [15:0] left;
        logic signed [15:0] top;
        logic signed [15:0] right;
        logic signed [15:0] bottom;
        logic [15:0]        health;
        logic [15:0]        health_full;
    } box_summary_t;

    function automatic logic signed [15:0] sat16(input logic signed [23:0] v);
        if (v > 24'sd32767)
            return 16'sh7fff;
        else if (v < -24'sd32768)
            return 16'sh8000;
        else
            return v[15:0];
    endfunction

endpackage

/* src/bsp_if.sv */
// Valid/ready channel interfaces for box words in and result words out.
// Depends on nothing.
interface bsp_box_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] box_min_x;
    logic signed [31:0] box_min_y;
    logic signed [31:0] box_min_z;
    logic signed [31:0] box_max_x;
    logic signed [31:0] box_max_y;
    logic signed [31:0] box_max_z;
    logic [15:0]        health_now;
    logic [15:0]        health_full;

    modport source (output valid, box_min_x, box_min_y, box_min_z, box_max_x, box_max_y,
                    box_max_z, health_now, health_full, input ready);
    modport sink (input valid, box_min_x, box_min_y, box_min_z, box_max_x, box_max_y,
                  box_max_z, health_now, health_full, output ready);
endinterface

interface bsp_result_if;
    logic               valid;
    logic               ready;
    logic               visible;
    logic               draw_box;
    logic signed [15:0] rect_left;
    logic signed [15:0] rect_top;
    logic signed [15:0] rect_right;
    logic signed [15:0] rect_bottom;
    logic               bar_shown;
    logic signed [15:0] bar_fill_top;
    logic [7:0]         bar_red;
    logic [7:0]         bar_green;

    modport source (output valid, visible, draw_box, rect_left, rect_top, rect_right,
                    rect_bottom, bar_shown, bar_fill_top, bar_red, bar_green, input ready);
    modport sink (input valid, visible, draw_box, rect_left, rect_top, rect_right,
                  rect_bottom, bar_shown, bar_fill_top, bar_red, bar_green, output ready);
endinterface

/* src/box_screen_projection.sv */
// Top level of the box screen projection block: configuration registers and
// the four pipeline parts. Depends on bsp_pkg, bsp_if and the bsp_* modules.
//
//  channel     direction  word
//  box_in      in         one box and a health pair
//  result_out  out        screen rectangle and health bar
//  cfg_*       in         register write, index and data
//
// Each box gives eight corners, which enter the projection pipeline one a
// cycle while result_out is not stalled; a new box is taken as the last
// corner of the one before is issued, so boxes run back to back. The two
// bit-per-stage dividers have 20 stages for the offsets and 16 for the bar.
// Reset clears the registers and all valid bits; no clearing pass is needed.
// A stall on result_out holds the whole pipeline in place.
module box_screen_projection (
    input  logic        clk,
    input  logic        rst_n,
    bsp_box_if.sink     box_in,
    bsp_result_if.source result_out,
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_wdata
);
    import bsp_pkg::*;

    logic signed [31:0] cam_x_reg, cam_y_reg, cam_z_reg;
    logic [47:0]        right_reg, up_reg, forward_reg;
    logic [63:0]        scales_reg;
    logic [1:0]         mode_reg;
    logic [31:0]        scale_x_reg, scale_y_reg;
    proj_cfg_t          pcfg;

    logic               adv;
    logic               corner_valid;
    corner_tag_t        corner_tag;
    logic signed [32:0] local_x, local_y, local_z;
    logic               screen_valid;
    corner_tag_t        screen_tag;
    logic               screen_front;
    logic signed [15:0] pix_x, pix_y;
    logic               summary_valid;
    box_summary_t       summary;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cam_x_reg   <= '0;
            cam_y_reg   <= '0;
            cam_z_reg   <= '0;
            right_reg   <= '0;
            up_reg      <= '0;
            forward_reg <= '0;
            scales_reg  <= '0;
            mode_reg    <= '0;
            scale_x_reg <= '0;
            scale_y_reg <= '0;
        end
        else
        begin
            // Focal scale times half size, kept ready for the offset multiply.
            scale_x_reg <= 32'(scales_reg[15:0]) * 32'(scales_reg[47:32]);
            scale_y_reg <= 32'(scales_reg[31:16]) * 32'(scales_reg[63:48]);
            if (cfg_wr_en)
            begin
                case (cfg_reg_t'(cfg_index))
                    REG_CAMERA_X:          cam_x_reg   <= cfg_wdata[31:0];
                    REG_CAMERA_Y:          cam_y_reg   <= cfg_wdata[31:0];
                    REG_CAMERA_Z:          cam_z_reg   <= cfg_wdata[31:0];
                    REG_RIGHT_AXIS:        right_reg   <= cfg_wdata[47:0];
                    REG_UP_AXIS:           up_reg      <= cfg_wdata[47:0];
                    REG_FORWARD_AXIS:      forward_reg <= cfg_wdata[47:0];
                    REG_PROJECTION_SCALES: scales_reg  <= cfg_wdata;
                    REG_MODE_FLAGS:        mode_reg    <= cfg_wdata[1:0];
                    default:               mode_reg    <= mode_reg;
                endcase
            end
        end
    end

    always_comb
    begin
        pcfg.right_axis   = right_reg;
        pcfg.up_axis      = up_reg;
        pcfg.forward_axis = forward_reg;
        pcfg.scale_x      = scale_x_reg;
        pcfg.scale_y      = scale_y_reg;
        pcfg.half_w       = scales_reg[47:32];
        pcfg.half_h       = scales_reg[63:48];
    end

    bsp_corner_gen u_gen (
        .clk          (clk),
        .rst_n        (rst_n),
        .adv          (adv),
        .box_in       (box_in),
        .cam_x        (cam_x_reg),
        .cam_y        (cam_y_reg),
        .cam_z        (cam_z_reg),
        .corner_valid (corner_valid),
        .corner_tag   (corner_tag),
        .local_x      (local_x),
        .local_y      (local_y),
        .local_z      (local_z)
    );

    bsp_corner_proj u_proj (
        .clk          (clk),
        .rst_n        (rst_n),
        .adv          (adv),
        .cfg          (pcfg),
        .corner_valid (corner_valid),
        .corner_tag   (corner_tag),
        .local_x      (local_x),
        .local_y      (local_y),
        .local_z      (local_z),
        .screen_valid (screen_valid),
        .screen_tag   (screen_tag),
        .screen_front (screen_front),
        .pix_x        (pix_x),
        .pix_y        (pix_y)
    );

    bsp_box_reduce u_reduce (
        .clk           (clk),
        .rst_n         (rst_n),
        .adv           (adv),
        .mode_flags    (mode_reg),
        .screen_valid  (screen_valid),
        .screen_tag    (screen_tag),
        .screen_front  (screen_front),
        .pix_x         (pix_x),
        .pix_y         (pix_y),
        .summary_valid (summary_valid),
        .summary       (summary)
    );

    bsp_health_bar u_bar (
        .clk           (clk),
        .rst_n         (rst_n),
        .adv           (adv),
        .summary_valid (summary_valid),
        .summary       (summary),
        .result_out    (result_out)
    );

endmodule

/* src/bsp_corner_gen.sv */
// Corner sequencer: holds one box and issues its eight corners, one a cycle
// while adv is high, as offsets from the camera. Depends on bsp_pkg and bsp_if.
module bsp_corner_gen (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      adv,
    bsp_box_if.sink                   box_in,
    input  logic signed [31:0]        cam_x,
    input  logic signed [31:0]        cam_y,
    input  logic signed [31:0]        cam_z,
    output logic                      corner_valid,
    output bsp_pkg::corner_tag_t      corner_tag,
    output logic signed [32:0]        local_x,
    output logic signed [32:0]        local_y,
    output logic signed [32:0]        local_z
);
    import bsp_pkg::*;

    localparam logic [2:0] CORNER_LAST = 3'(NUM_CORNERS - 1);

    logic               busy_reg, busy_next;
    logic [2:0]         corner_reg, corner_next;
    logic signed [31:0] lo_reg [3];
    logic signed [31:0] hi_reg [3];
    logic [15:0]        hnow_reg, hfull_reg;
    logic               valid_reg;
    corner_tag_t        tag_reg;
    logic signed [32:0] lx_reg, ly_reg, lz_reg;
    logic               accept;

    assign box_in.ready = !busy_reg || (adv && corner_reg == CORNER_LAST);
    assign accept       = box_in.valid && box_in.ready;

    always_comb
    begin
        busy_next   = busy_reg;
        corner_next = corner_reg;
        if (busy_reg && adv)
        begin
            corner_next = corner_reg + 3'd1;
            if (corner_reg == CORNER_LAST)
            begin
                busy_next   = accept;
                corner_next = '0;
            end
        end
        else if (!busy_reg && accept)
        begin
            busy_next   = 1'b1;
            corner_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg   <= 1'b0;
            corner_reg <= '0;
            valid_reg  <= 1'b0;
        end
        else
        begin
            busy_reg   <= busy_next;
            corner_reg <= corner_next;
            if (adv)
                valid_reg <= busy_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            lo_reg[0] <= box_in.box_min_x;
            lo_reg[1] <= box_in.box_min_y;
            lo_reg[2] <= box_in.box_min_z;
            hi_reg[0] <= box_in.box_max_x;
            hi_reg[1] <= box_in.box_max_y;
            hi_reg[2] <= box_in.box_max_z;
            hnow_reg  <= box_in.health_now;
            hfull_reg <= box_in.health_full;
        end
        if (adv)
        begin
            lx_reg <= 33'(corner_reg[0] ? hi_reg[0] : lo_reg[0]) - 33'(cam_x);
            ly_reg <= 33'(corner_reg[1] ? hi_reg[1] : lo_reg[1]) - 33'(cam_y);
            lz_reg <= 33'(corner_reg[2] ? hi_reg[2] : lo_reg[2]) - 33'(cam_z);
            tag_reg.first       <= (corner_reg == '0);
            tag_reg.last        <= (corner_reg == CORNER_LAST);
            tag_reg.health_now  <= hnow_reg;
            tag_reg.health_full <= hfull_reg;
        end
    end

    assign corner_valid = valid_reg;
    assign corner_tag   = tag_reg;
    assign local_x      = lx_reg;
    assign local_y      = ly_reg;
    assign local_z      = lz_reg;

endmodule

/* src/bsp_corner_proj.sv */
// Corner projection pipeline: camera-basis dot products, scale multiply and
// a bit-per-stage divider down to saturated screen x and y. Depends on bsp_pkg.
module bsp_corner_proj (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      adv,
    input  bsp_pkg::proj_cfg_t        cfg,
    input  logic                      corner_valid,
    input  bsp_pkg::corner_tag_t      corner_tag,
    input  logic signed [32:0]        local_x,
    input  logic signed [32:0]        local_y,
    input  logic signed [32:0]        local_z,
    output logic                      screen_valid,
    output bsp_pkg::corner_tag_t      screen_tag,
    output logic                      screen_front,
    output logic signed [15:0]        pix_x,
    output logic signed [15:0]        pix_y
);
    import bsp_pkg::*;

    localparam int DIV_STEPS = 20;

    typedef struct packed {
        corner_tag_t tag;
        logic        front;
        logic        neg_x;
        logic        neg_y;
        logic        cap_x;
        logic        cap_y;
        logic [57:0] d;
    } div_side_t;

    logic signed [32:0] lvec [3];
    logic signed [15:0] comp [3][3];
    logic [47:0]        axis [3];
    logic [31:0]        mscale [2];

    // stage: products
    logic               v_prod_reg;
    corner_tag_t        tag_prod_reg;
    logic signed [48:0] prod_reg [3][3];
    // stage: dot sums, magnitudes
    logic               v_dot_reg;
    corner_tag_t        tag_dot_reg;
    logic               front_dot_reg;
    logic               neg_dot_reg [2];
    logic [49:0]        mag_dot_reg [2];
    logic [57:0]        d_dot_reg;
    logic signed [50:0] dot_sum [3];
    // stage: partial products
    logic               v_pp_reg;
    div_side_t          side_pp_reg;
    logic [56:0]        pp_lo_reg [2];
    logic [56:0]        pp_hi_reg [2];
    // stage: numerator
    logic               v_num_reg;
    div_side_t          side_num_reg;
    logic [81:0]        num_reg [2];
    // divider stages, index 0 is the cap test
    logic               v_div_reg [DIV_STEPS + 1];
    div_side_t          side_div_reg [DIV_STEPS + 1];
    logic [77:0]        rem_reg [2][DIV_STEPS + 1];
    logic [DIV_STEPS-1:0] q_reg [2][DIV_STEPS + 1];
    // output stage
    logic               v_out_reg;
    corner_tag_t        tag_out_reg;
    logic               front_out_reg;
    logic signed [15:0] sx_reg, sy_reg;

    assign lvec[0]   = local_x;
    assign lvec[1]   = local_y;
    assign lvec[2]   = local_z;
    assign axis[0]   = cfg.right_axis;
    assign axis[1]   = cfg.up_axis;
    assign axis[2]   = cfg.forward_axis;
    assign mscale[0] = cfg.scale_x;
    assign mscale[1] = cfg.scale_y;

    always_comb
    begin
        for (int a = 0; a < 3; a++)
            for (int k = 0; k < 3; k++)
                comp[a][k] = $signed(axis[a][16*k +: 16]);
        for (int a = 0; a < 3; a++)
            dot_sum[a] = 51'(prod_reg[a][0]) + 51'(prod_reg[a][1]) + 51'(prod_reg[a][2]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_prod_reg <= 1'b0;
            v_dot_reg  <= 1'b0;
            v_pp_reg   <= 1'b0;
            v_num_reg  <= 1'b0;
            v_out_reg  <= 1'b0;
        end
        else if (adv)
        begin
            v_prod_reg <= corner_valid;
            v_dot_reg  <= v_prod_reg;
            v_pp_reg   <= v_dot_reg;
            v_num_reg  <= v_pp_reg;
            v_out_reg  <= v_div_reg[DIV_STEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            tag_prod_reg <= corner_tag;
            for (int a = 0; a < 3; a++)
                for (int k = 0; k < 3; k++)
                    prod_reg[a][k] <= 49'(lvec[k]) * 49'(comp[a][k]);

            tag_dot_reg   <= tag_prod_reg;
            front_dot_reg <= dot_sum[2] >= 51'(DEPTH_MIN_Q22);
            d_dot_reg     <= {dot_sum[2][49:0], 8'd0};
            for (int j = 0; j < 2; j++)
            begin
                neg_dot_reg[j] <= dot_sum[j][50];
                mag_dot_reg[j] <= dot_sum[j][50] ? 50'(-dot_sum[j]) : 50'(dot_sum[j]);
            end

            side_pp_reg.tag   <= tag_dot_reg;
            side_pp_reg.front <= front_dot_reg;
            side_pp_reg.neg_x <= neg_dot_reg[0];
            side_pp_reg.neg_y <= neg_dot_reg[1];
            side_pp_reg.cap_x <= 1'b0;
            side_pp_reg.cap_y <= 1'b0;
            side_pp_reg.d     <= d_dot_reg;
            for (int j = 0; j < 2; j++)
            begin
                pp_lo_reg[j] <= 57'(mag_dot_reg[j][24:0]) * 57'(mscale[j]);
                pp_hi_reg[j] <= 57'(mag_dot_reg[j][49:25]) * 57'(mscale[j]);
            end

            side_num_reg <= side_pp_reg;
            for (int j = 0; j < 2; j++)
                num_reg[j] <= 82'(pp_lo_reg[j]) + (82'(pp_hi_reg[j]) << 25);
        end
    end

    // Cap test: a quotient of 2^20 or more is reported as 2^20 exactly.
    logic      cap_now [2];
    div_side_t side_cap;
    always_comb
    begin
        for (int j = 0; j < 2; j++)
            cap_now[j] = num_reg[j] >= (82'(side_num_reg.d) << DIV_STEPS);
        side_cap       = side_num_reg;
        side_cap.cap_x = cap_now[0];
        side_cap.cap_y = cap_now[1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_div_reg[0] <= 1'b0;
        else if (adv)
            v_div_reg[0] <= v_num_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            side_div_reg[0] <= side_cap;
            for (int j = 0; j < 2; j++)
            begin
                rem_reg[j][0] <= num_reg[j][77:0];
                q_reg[j][0]   <= '0;
            end
        end
    end

    for (genvar s = 1; s <= DIV_STEPS; s++)
    begin : g_div
        localparam int SH = DIV_STEPS - s;
        logic [77:0] dsh;
        logic        take [2];

        always_comb
        begin
            dsh = 78'(side_div_reg[s-1].d) << SH;
            for (int j = 0; j < 2; j++)
                take[j] = rem_reg[j][s-1] >= dsh;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_div_reg[s] <= 1'b0;
            else if (adv)
                v_div_reg[s] <= v_div_reg[s-1];
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                side_div_reg[s] <= side_div_reg[s-1];
                for (int j = 0; j < 2; j++)
                begin
                    rem_reg[j][s] <= take[j] ? rem_reg[j][s-1] - dsh : rem_reg[j][s-1];
                    q_reg[j][s]   <= {q_reg[j][s-1][DIV_STEPS-2:0], take[j]};
                end
            end
        end
    end

    div_side_t          side_last;
    logic [20:0]        off_x, off_y;
    logic signed [23:0] soff_x, soff_y;

    always_comb
    begin
        side_last = side_div_reg[DIV_STEPS];
        off_x  = side_last.cap_x ? 21'(OFFSET_CAP) : 21'(q_reg[0][DIV_STEPS]);
        off_y  = side_last.cap_y ? 21'(OFFSET_CAP) : 21'(q_reg[1][DIV_STEPS]);
        soff_x = side_last.neg_x ? -$signed(24'(off_x)) : $signed(24'(off_x));
        soff_y = side_last.neg_y ? -$signed(24'(off_y)) : $signed(24'(off_y));
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            tag_out_reg   <= side_last.tag;
            front_out_reg <= side_last.front;
            sx_reg <= sat16($signed(24'(cfg.half_w)) + soff_x);
            sy_reg <= sat16($signed(24'(cfg.half_h)) - soff_y);
        end
    end

    assign screen_valid = v_out_reg;
    assign screen_tag   = tag_out_reg;
    assign screen_front = front_out_reg;
    assign pix_x        = sx_reg;
    assign pix_y        = sy_reg;

endmodule

/* src/bsp_box_reduce.sv */
// Rectangle reduction: counts corners in front and tracks the least and
// greatest screen x and y over one box. Depends on bsp_pkg.
module bsp_box_reduce (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  adv,
    input  logic [1:0]            mode_flags,
    input  logic                  screen_valid,
    input  bsp_pkg::corner_tag_t  screen_tag,
    input  logic                  screen_front,
    input  logic signed [15:0]    pix_x,
    input  logic signed [15:0]    pix_y,
    output logic                  summary_valid,
    output bsp_pkg::box_summary_t summary
);
    import bsp_pkg::*;

    logic [3:0]         cnt_reg, cnt_base, cnt_new;
    logic signed [15:0] left_reg, top_reg, right_reg, bottom_reg;
    logic signed [15:0] left_new, top_new, right_new, bottom_new;
    logic               sum_valid_reg;
    box_summary_t       sum_reg, sum_new;
    logic               vis;

    always_comb
    begin
        cnt_base   = screen_tag.first ? 4'd0 : cnt_reg;
        left_new   = left_reg;
        top_new    = top_reg;
        right_new  = right_reg;
        bottom_new = bottom_reg;
        cnt_new    = cnt_base;
        if (screen_front)
        begin
            cnt_new = cnt_base + 4'd1;
            if (cnt_base == 4'd0)
            begin
                left_new   = pix_x;
                right_new  = pix_x;
                top_new    = pix_y;
                bottom_new = pix_y;
            end
            else
            begin
                if (pix_x < left_reg)
                    left_new = pix_x;
                if (pix_x > right_reg)
                    right_new = pix_x;
                if (pix_y < top_reg)
                    top_new = pix_y;
                if (pix_y > bottom_reg)
                    bottom_new = pix_y;
            end
        end
        vis = cnt_new >= 4'(MIN_CORNERS);
        sum_new.visible     = vis;
        sum_new.draw_box    = vis && mode_flags[0];
        sum_new.bar_on      = vis && mode_flags[1] && (screen_tag.health_full != '0);
        sum_new.left        = left_new;
        sum_new.top         = top_new;
        sum_new.right       = right_new;
        sum_new.bottom      = bottom_new;
        sum_new.health      = (screen_tag.health_now > screen_tag.health_full)
                              ? screen_tag.health_full : screen_tag.health_now;
        sum_new.health_full = screen_tag.health_full;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            sum_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            sum_valid_reg <= screen_valid && screen_tag.last;
            if (screen_valid)
                cnt_reg <= cnt_new;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            if (screen_valid)
            begin
                left_reg   <= left_new;
                top_reg    <= top_new;
                right_reg  <= right_new;
                bottom_reg <= bottom_new;
            end
            sum_reg <= sum_new;
        end
    end

    assign summary_valid = sum_valid_reg;
    assign summary       = sum_reg;

endmodule

/* src/bsp_health_bar.sv */
// Health bar pipeline and output register: fill height and colour through a
// bit-per-stage divider, then the result word. Depends on bsp_pkg and bsp_if.
module bsp_health_bar (
    input  logic                  clk,
    input  logic                  rst_n,
    output logic                  adv,
    input  logic                  summary_valid,
    input  bsp_pkg::box_summary_t summary,
    bsp_result_if.source          result_out
);
    import bsp_pkg::*;

    localparam int QW = 16;

    logic               v_reg [QW + 1];
    box_summary_t       sum_reg [QW + 1];
    logic               upper_reg [QW + 1];
    logic [31:0]        remf_reg [QW + 1];
    logic [31:0]        remc_reg [QW + 1];
    logic [QW-1:0]      qf_reg [QW + 1];
    logic [QW-1:0]      qc_reg [QW + 1];

    logic               out_valid_reg;
    logic               out_vis_reg, out_draw_reg, out_bar_reg;
    logic signed [15:0] out_l_reg, out_t_reg, out_r_reg, out_b_reg, out_fill_reg;
    logic [7:0]         out_red_reg, out_green_reg;

    logic [15:0]        height;
    logic               upper;
    logic [15:0]        colour_base;
    logic signed [16:0] span;

    assign adv = !out_valid_reg || result_out.ready;

    always_comb
    begin
        span        = 17'(summary.bottom) - 17'(summary.top);
        height      = span[15:0];
        upper       = {summary.health, 1'b0} > {1'b0, summary.health_full};
        colour_base = upper ? summary.health_full - summary.health : summary.health;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg[0] <= 1'b0;
        else if (adv)
            v_reg[0] <= summary_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sum_reg[0]   <= summary;
            upper_reg[0] <= upper;
            remf_reg[0]  <= 32'(height) * 32'(summary.health);
            remc_reg[0]  <= 32'(COLOUR_SCALE) * 32'(colour_base);
            qf_reg[0]    <= '0;
            qc_reg[0]    <= '0;
        end
    end

    for (genvar s = 1; s <= QW; s++)
    begin : g_div
        localparam int SH = QW - s;
        logic [31:0] dsh;
        logic        take_f, take_c;

        always_comb
        begin
            dsh    = 32'(sum_reg[s-1].health_full) << SH;
            take_f = remf_reg[s-1] >= dsh;
            take_c = remc_reg[s-1] >= dsh;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[s] <= 1'b0;
            else if (adv)
                v_reg[s] <= v_reg[s-1];
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                sum_reg[s]   <= sum_reg[s-1];
                upper_reg[s] <= upper_reg[s-1];
                remf_reg[s]  <= take_f ? remf_reg[s-1] - dsh : remf_reg[s-1];
                remc_reg[s]  <= take_c ? remc_reg[s-1] - dsh : remc_reg[s-1];
                qf_reg[s]    <= {qf_reg[s-1][QW-2:0], take_f};
                qc_reg[s]    <= {qc_reg[s-1][QW-2:0], take_c};
            end
        end
    end

    box_summary_t sl;
    logic         vis, bar;
    assign sl  = sum_reg[QW];
    assign vis = sl.visible;
    assign bar = sl.bar_on;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv)
            out_valid_reg <= v_reg[QW];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_vis_reg  <= vis;
            out_draw_reg <= sl.draw_box;
            out_bar_reg  <= bar;
            out_l_reg    <= vis ? sl.left : '0;
            out_t_reg    <= vis ? sl.top : '0;
            out_r_reg    <= vis ? sl.right : '0;
            out_b_reg    <= vis ? sl.bottom : '0;
            out_fill_reg <= bar ? sat16(24'(sl.bottom) - $signed(24'(qf_reg[QW]))) : '0;
            if (!bar)
            begin
                out_red_reg   <= '0;
                out_green_reg <= '0;
            end
            else if (upper_reg[QW])
            begin
                out_red_reg   <= qc_reg[QW][7:0];
                out_green_reg <= 8'(COLOUR_FULL);
            end
            else
            begin
                out_red_reg   <= 8'(COLOUR_FULL);
                out_green_reg <= qc_reg[QW][7:0];
            end
        end
    end

    assign result_out.valid        = out_valid_reg;
    assign result_out.visible      = out_vis_reg;
    assign result_out.draw_box     = out_draw_reg;
    assign result_out.rect_left    = out_l_reg;
    assign result_out.rect_top     = out_t_reg;
    assign result_out.rect_right   = out_r_reg;
    assign result_out.rect_bottom  = out_b_reg;
    assign result_out.bar_shown    = out_bar_reg;
    assign result_out.bar_fill_top = out_fill_reg;
    assign result_out.bar_red      = out_red_reg;
    assign result_out.bar_green    = out_green_reg;

endmodule
